### hdl/ebd_pkg.sv
// Package for the edge-timed bit destuffing receiver: widths, item types, gap classes.
`default_nettype none
package ebd_pkg;

    localparam int TIME_BITS  = 32;
    localparam int PERIOD_W   = 16;
    localparam int FLAG_W     = 8;
    localparam int COUNT_W    = 10;
    localparam int RUN_W      = 3;
    localparam int THR_W      = PERIOD_W + 3;
    localparam int CMP_W      = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLAG       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_LIMIT  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [FLAG_W-1:0]   FLAG_RST   = 8'h7E;
    localparam logic [COUNT_W-1:0]  LIMIT_RST  = 10'd800;

    localparam logic [RUN_W-1:0]   STUFF_RUN = 3'd5;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [FLAG_W-1:0]  WIN_RESTART = 8'h01;

    typedef struct packed {
        logic [TIME_BITS-1:0] edge_time;
        logic                 line_level;
    } in_item_t;

    typedef struct packed {
        logic               bit_valid;
        logic               bit_value;
        logic               frame_restart;
        logic               frame_done;
        logic               error_flag;
        logic [COUNT_W-1:0] bits_so_far;
    } out_item_t;

    typedef struct packed {
        logic [THR_W-1:0] t1;
        logic [THR_W-1:0] t3;
        logic [THR_W-1:0] t5;
        logic [THR_W-1:0] tl;
    } thr_t;

    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SKIP,
        GAP_DATA,
        GAP_LONG
    } gap_t;

    function automatic thr_t thr_calc(input logic [PERIOD_W-1:0] period);
        logic [THR_W-1:0] p;
        thr_t             t;
        p    = {3'b000, period};
        t.t1 = p >> 1;
        t.t3 = (p + (p << 1)) >> 1;
        t.t5 = (p + (p << 2)) >> 1;
        t.tl = t.t1 + (t.t1 << 2);
        return t;
    endfunction

endpackage
`default_nettype wire

### hdl/ebd_cfg.sv
// Configuration registers with gap thresholds precomputed on each period write.
`default_nettype none
module ebd_cfg
    import ebd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [PERIOD_W-1:0]   cfg_wdata,
    output thr_t                       thr,
    output logic [FLAG_W-1:0]          flag_pattern,
    output logic [COUNT_W-1:0]         bit_limit
);

    thr_t               thr_reg;
    logic [FLAG_W-1:0]  flag_reg;
    logic [COUNT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= thr_calc(PERIOD_RST);
            flag_reg  <= FLAG_RST;
            limit_reg <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BIT_PERIOD: thr_reg   <= thr_calc(cfg_wdata);
                REG_FLAG:       flag_reg  <= cfg_wdata[FLAG_W-1:0];
                REG_BIT_LIMIT:  limit_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign thr          = thr_reg;
    assign flag_pattern = flag_reg;
    assign bit_limit    = limit_reg;

endmodule
`default_nettype wire

### hdl/ebd_gap.sv
// Gap classifier: elapsed time since the last bit against the period thresholds.
`default_nettype none
module ebd_gap
    import ebd_pkg::*;
(
    input  wire logic [TIME_BITS-1:0] now,
    input  wire logic [TIME_BITS-1:0] last_time,
    input  wire thr_t                 thr,
    output gap_t                      gap
);

    logic [TIME_BITS-1:0] dt_raw;
    logic [CMP_W-1:0]     dt;
    logic [CMP_W-1:0]     t1, t3, t5, tl;

    assign dt_raw = now - last_time;
    assign dt     = CMP_W'(dt_raw);
    assign t1     = CMP_W'(thr.t1);
    assign t3     = CMP_W'(thr.t3);
    assign t5     = CMP_W'(thr.t5);
    assign tl     = CMP_W'(thr.tl);

    always_comb begin
        if (dt > t1 && dt < t3) begin
            gap = GAP_SKIP;
        end else if (dt > t3 && dt < t5) begin
            gap = GAP_DATA;
        end else if (dt > tl) begin
            gap = GAP_LONG;
        end else begin
            gap = GAP_NONE;
        end
    end

endmodule
`default_nettype wire

### hdl/edge_timed_bit_destuff_receiver.sv
// Top level of the edge-timed bit destuffing receiver: handshake, frame state, result register.
//
// Usage: each input item on s_ is one line edge (timestamp in microseconds, level after
// the edge). Every accepted item gives exactly one result item on m_: the appended data
// bit if any, a restart mark, the sticky done and error flags and the frame bit count.
// Configuration goes through cfg_wr_en/cfg_addr/cfg_wdata (0 bit period, 1 flag pattern,
// 2 frame bit limit); write it only while no item is in flight.
// Path: an accepted item is held in the input register, its result is formed by one pass
// of logic and registered in the result register when it may advance, that is when the
// result register is empty or m_ready is high.
// Throughput: one item per cycle while m_ready is high; the frame state updates in the same
// cycle its result is registered, so each item sees the state left by the previous one.
// When m_ready is low the result register and the input register each hold one item;
// s_ready falls once both are full and rises again in the cycle m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, restores the register defaults
// and the frame state: window and counters zero, awaiting a start flag.
`default_nettype none
module edge_timed_bit_destuff_receiver
    import ebd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [PERIOD_W-1:0]   cfg_wdata
);

    thr_t               thr;
    logic [FLAG_W-1:0]  flag_pattern;
    logic [COUNT_W-1:0] bit_limit;
    gap_t               gap;

    logic               in_vld_reg;
    in_item_t           in_reg;
    logic               out_vld_reg;
    out_item_t          out_reg;
    logic               adv;

    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [FLAG_W-1:0]    win_reg, win_next, win_shift;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic                 await_reg, await_next;
    logic                 err_reg, err_next;
    out_item_t            res;
    logic                 dbit;

    ebd_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .thr          (thr),
        .flag_pattern (flag_pattern),
        .bit_limit    (bit_limit)
    );

    ebd_gap u_gap (
        .now       (in_reg.edge_time),
        .last_time (last_reg),
        .thr       (thr),
        .gap       (gap)
    );

    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    assign dbit      = ~in_reg.line_level;
    assign win_shift = {win_reg[FLAG_W-2:0], dbit};

    always_comb begin
        last_next  = last_reg;
        win_next   = win_reg;
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg || (cnt_reg > bit_limit);
        await_next = await_reg;
        err_next   = err_reg;
        res        = '0;

        if (!done_next) begin
            case (gap)
                GAP_DATA: begin
                    win_next  = win_shift;
                    last_next = in_reg.edge_time;
                    if (run_reg == STUFF_RUN && dbit) begin
                        run_next = '0;
                    end else begin
                        res.bit_valid = 1'b1;
                        res.bit_value = dbit;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (win_shift == flag_pattern) begin
                            if (await_reg) begin
                                await_next = 1'b0;
                            end else begin
                                done_next  = 1'b1;
                                await_next = 1'b1;
                            end
                        end
                        if (!dbit) begin
                            if (run_reg != RUN_MAX) begin
                                run_next = run_reg + 1'b1;
                            end
                        end else begin
                            run_next = '0;
                        end
                    end
                end
                GAP_LONG: begin
                    if (dbit) begin
                        last_next         = in_reg.edge_time;
                        await_next        = 1'b1;
                        win_next          = WIN_RESTART;
                        res.bit_valid     = 1'b1;
                        res.bit_value     = 1'b1;
                        res.frame_restart = 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        res.frame_done  = done_next;
        res.error_flag  = err_next;
        res.bits_so_far = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            last_reg    <= '0;
            win_reg     <= '0;
            run_reg     <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            await_reg   <= 1'b1;
            err_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
                in_reg     <= s_data;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
                out_reg     <= res;
                last_reg    <= last_next;
                win_reg     <= win_next;
                run_reg     <= run_next;
                cnt_reg     <= cnt_next;
                done_reg    <= done_next;
                await_reg   <= await_next;
                err_reg     <= err_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the edge-timed bit destuffing receiver.
module testbench
    import ebd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] gap;
        logic                 level;
        logic                 typed;
        out_item_t            want;
    } probe_t;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED  = 2'd3;
    localparam int                    QUIET_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [PERIOD_W-1:0]   cfg_wdata = '0;

    // receiver copy of settings and frame state
    logic [PERIOD_W-1:0]  cfg_period;
    logic [FLAG_W-1:0]    cfg_flag;
    logic [COUNT_W-1:0]   cfg_limit;
    logic [TIME_BITS-1:0] rx_last;
    logic [FLAG_W-1:0]    rx_window;
    logic [RUN_W-1:0]     rx_zeros;
    logic [COUNT_W-1:0]   rx_count;
    logic                 rx_done;
    logic                 rx_hunt;
    logic                 rx_err;

    out_item_t owed_reports[$];
    logic      bit_plan[$];
    int        mismatches     = 0;
    int        quiet_cycles   = 0;
    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    logic      flag_done_ok   = 1'b0;

    // gap, level, typed, expected (valid, value, restart, done, error, bits)
    probe_t probes [21] = '{
        '{32'd0,    1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}},
        '{32'd1000, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}},
        '{32'd2000, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd1}},
        '{32'd500,  1'b0, 1'b0, '0},
        '{32'd1500, 1'b0, 1'b0, '0},
        '{32'd2500, 1'b0, 1'b0, '0},
        '{32'd2501, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 10'd1}},
        '{32'd3000, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 10'd1}},
        // opening flag 0x7E
        '{32'd2000, 1'b1, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0},
        '{32'd2000, 1'b1, 1'b0, '0},
        // four more zeros make five, then the stuffed one is dropped
        '{32'd2000, 1'b1, 1'b0, '0},
        '{32'd2000, 1'b1, 1'b0, '0},
        '{32'd2000, 1'b1, 1'b0, '0},
        '{32'd2000, 1'b1, 1'b0, '0},
        '{32'd2000, 1'b0, 1'b0, '0}
    };

    edge_timed_bit_destuff_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint unsigned half_of(input int unsigned k);
        longint unsigned p;
        p = cfg_period;
        return (k * p) / 2;
    endfunction

    function automatic out_item_t resolve_edge(input in_item_t it);
        out_item_t            r;
        logic [TIME_BITS-1:0] dt;
        logic                 dbit;
        gap_t                 kind;
        r    = '0;
        dbit = ~it.line_level;
        if (rx_count > cfg_limit) rx_done = 1'b1;
        if (!rx_done) begin
            dt = it.edge_time - rx_last;
            if (dt > half_of(1) && dt < half_of(3)) kind = GAP_SKIP;
            else if (dt > half_of(3) && dt < half_of(5)) kind = GAP_DATA;
            else if (dt > 5 * half_of(1)) kind = GAP_LONG;
            else kind = GAP_NONE;
            case (kind)
                GAP_DATA: begin
                    rx_window = {rx_window[FLAG_W-2:0], dbit};
                    if (rx_zeros == STUFF_RUN && dbit) begin
                        rx_zeros = '0;
                    end else begin
                        r.bit_valid = 1'b1;
                        r.bit_value = dbit;
                        if (rx_count != COUNT_MAX) rx_count++;
                        if (rx_window == cfg_flag) begin
                            if (rx_hunt) begin
                                rx_hunt = 1'b0;
                            end else begin
                                rx_done = 1'b1;
                                rx_hunt = 1'b1;
                            end
                        end
                        if (dbit) rx_zeros = '0;
                        else if (rx_zeros != RUN_MAX) rx_zeros++;
                    end
                    rx_last = it.edge_time;
                end
                GAP_LONG: begin
                    if (dbit) begin
                        rx_last         = it.edge_time;
                        rx_hunt         = 1'b1;
                        rx_window       = WIN_RESTART;
                        r.bit_valid     = 1'b1;
                        r.bit_value     = 1'b1;
                        r.frame_restart = 1'b1;
                    end else begin
                        rx_err = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.frame_done  = rx_done;
        r.error_flag  = rx_err;
        r.bits_so_far = rx_count;
        return r;
    endfunction

    // next line edge, timed against the current bit reference
    function automatic in_item_t next_edge();
        in_item_t    it;
        int unsigned t1, t3, t5, tl, gap;
        int          roll;
        logic        dbit;
        t1   = 32'(half_of(1));
        t3   = 32'(half_of(3));
        t5   = 32'(half_of(5));
        tl   = 5 * t1;
        roll = $urandom_range(99);
        it.line_level = 1'($urandom_range(1));
        if (roll < 70 && t5 > t3 + 1) begin
            if (bit_plan.size() == 0) begin
                case ($urandom_range(9))
                    0, 1: for (int i = FLAG_W - 1; i >= 0; i--) bit_plan.push_back(cfg_flag[i]);
                    2: begin
                        repeat (5) bit_plan.push_back(1'b0);
                        bit_plan.push_back(1'b1);
                    end
                    default: bit_plan.push_back($urandom_range(99) >= 55);
                endcase
            end
            dbit = bit_plan.pop_front();
            // keep the frame open unless closing is allowed in this phase
            if (!flag_done_ok && !rx_hunt && {rx_window[FLAG_W-2:0], dbit} == cfg_flag
                && !(rx_zeros == STUFF_RUN && dbit))
                dbit = ~dbit;
            it.line_level = ~dbit;
            gap = $urandom_range(t5 - 1, t3 + 1);
        end else if (roll < 80 && t3 > t1 + 1) begin
            gap = $urandom_range(t3 - 1, t1 + 1);
        end else if (roll < 88) begin
            case ($urandom_range(4))
                0: gap = 0;
                1: gap = t1;
                2: gap = t3;
                3: gap = t5;
                default: gap = $urandom_range(t1);
            endcase
        end else if (roll < 95) begin
            gap = tl + 1 + $urandom_range(2000);
        end else begin
            it.edge_time = $urandom;
            return it;
        end
        it.edge_time = rx_last + gap;
        return it;
    endfunction

    task automatic send_edge(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = resolve_edge(it);
        owed_reports.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [PERIOD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_BIT_PERIOD: cfg_period = val;
            REG_FLAG:       cfg_flag   = val[FLAG_W-1:0];
            REG_BIT_LIMIT:  cfg_limit  = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (owed_reports.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [FLAG_W-1:0] flag,
                             input logic [COUNT_W-1:0] limit, input int count,
                             input idle_mode_t mode);
        write_reg(REG_BIT_PERIOD, period);
        write_reg(REG_FLAG, PERIOD_W'(flag));
        write_reg(REG_BIT_LIMIT, PERIOD_W'(limit));
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 55; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 55; end
            IDLE_BOTH: begin src_idle_pct = 27; sink_stall_pct = 27; end
            default:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
        bit_plan.delete();
        repeat (count) send_edge(next_edge(), 1'b0, '0);
        s_valid <= 1'b0;
        settle();
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (owed_reports.size() == 0) begin
                $display("%0t ns: unexpected result: expected none, got %p", $time, m_data);
                mismatches++;
            end else begin
                want = owed_reports.pop_front();
                if (m_data !== want) begin
                    $display("%0t ns: mismatch: expected %b %b %b %b %b %0d, got %b %b %b %b %b %0d",
                             $time, want.bit_valid, want.bit_value, want.frame_restart,
                             want.frame_done, want.error_flag, want.bits_so_far,
                             m_data.bit_valid, m_data.bit_value, m_data.frame_restart,
                             m_data.frame_done, m_data.error_flag, m_data.bits_so_far);
                    mismatches++;
                end
            end
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_item_t           it;
        logic               by_flag;
        logic [COUNT_W-1:0] cap;
        cfg_period = PERIOD_RST;
        cfg_flag   = FLAG_RST;
        cfg_limit  = LIMIT_RST;
        rx_last    = '0;
        rx_window  = '0;
        rx_zeros   = '0;
        rx_count   = '0;
        rx_done    = 1'b0;
        rx_hunt    = 1'b1;
        rx_err     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) begin
            it.edge_time  = rx_last + probes[i].gap;
            it.line_level = probes[i].level;
            send_edge(it, probes[i].typed, probes[i].want);
        end
        s_valid <= 1'b0;
        settle();

        run_phase(16'd1000, 8'h7E, 10'd1023, 220, IDLE_SRC);
        run_phase(16'd2, 8'($urandom), 10'd1023, 320, IDLE_SINK);
        run_phase(16'd65535, 8'h00, 10'd1023, 220, IDLE_BOTH);
        run_phase(16'd1, 8'hFF, 10'd1023, 50, IDLE_NONE);
        write_reg(REG_UNUSED, 16'($urandom));
        run_phase(16'd0, 8'hFF, 10'd1023, 50, IDLE_SRC);
        run_phase(16'($urandom_range(400, 2)), 8'($urandom), 10'd1023, 320, IDLE_SINK);
        run_phase(16'($urandom_range(65535, 3)), 8'h7E, 10'd1023, 260, IDLE_BOTH);
        run_phase(16'($urandom_range(50, 3)), 8'($urandom), 10'd1023, 380, IDLE_NONE);

        // close the frame by flag on some seeds, by the bit limit on the others
        by_flag      = 1'($urandom_range(1));
        flag_done_ok = by_flag;
        cap          = (rx_count > 10'd982) ? 10'd1022 : rx_count + 10'($urandom_range(40, 5));
        run_phase(16'($urandom_range(300, 4)), 8'h7E, by_flag ? 10'd1023 : cap, 180, IDLE_SRC);
        flag_done_ok = 1'b1;
        run_phase(16'd1000, 8'h7E, 10'd1, 40, IDLE_SINK);

        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
